### rtl/lps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types, codes and helpers of the LED pattern priority sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int NUM_LEVELS = 3;
    localparam int LEVEL_W    = 2;
    localparam int LVL_IDX_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int COLOR_W    = 2;
    localparam int PATTERN_W  = 4;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [LEVEL_W-1:0] NO_LEVEL      = 2'd3;
    localparam logic [2:0]         SLOW_DIV      = 3'd5;
    localparam logic [2:0]         SIX_MINUS_ONE = 3'd5;
    localparam logic [7:0]         SAT_MAX       = 8'hff;

    localparam logic [CFG_W-1:0] PULSE_PERIOD_RST = 8'd100;
    localparam logic [CFG_W-1:0] PULSE_WIDTH_RST  = 8'd2;
    localparam logic [CFG_W-1:0] ON_HOLD_RST      = 8'd30;
    localparam logic [CFG_W-1:0] OFF_HOLD_RST     = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_PERIOD = 2'd0,
        CFG_PULSE_WIDTH  = 2'd1,
        CFG_ON_HOLD      = 2'd2,
        CFG_OFF_HOLD     = 2'd3
    } cfg_idx_t;

    localparam logic [PATTERN_W-1:0] PAT_IDLE      = 4'd0;
    localparam logic [PATTERN_W-1:0] PAT_ON        = 4'd1;
    localparam logic [PATTERN_W-1:0] PAT_OFF       = 4'd2;
    localparam logic [PATTERN_W-1:0] PAT_PULSE     = 4'd3;
    localparam logic [PATTERN_W-1:0] PAT_BLINK     = 4'd4;
    localparam logic [PATTERN_W-1:0] PAT_TOGGLE6   = 4'd5;
    localparam logic [PATTERN_W-1:0] PAT_TOGGLE    = 4'd6;
    localparam logic [PATTERN_W-1:0] PAT_SLOW      = 4'd7;
    localparam logic [PATTERN_W-1:0] PAT_ON_TIMED  = 4'd8;
    localparam logic [PATTERN_W-1:0] PAT_SLOW6     = 4'd9;
    localparam logic [PATTERN_W-1:0] PAT_OFF_TIMED = 4'd10;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    typedef struct packed {
        logic                 req_type;
        logic [LEVEL_W-1:0]   level;
        logic [COLOR_W-1:0]   color;
        logic [PATTERN_W-1:0] pattern;
    } item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] drive_color;
        logic               led_on;
        logic [LEVEL_W-1:0] active_level;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] pulse_period_ticks;
        logic [CFG_W-1:0] pulse_width_ticks;
        logic [CFG_W-1:0] on_hold_ticks;
        logic [CFG_W-1:0] off_hold_ticks;
    } cfg_t;

    // x mod 5 == 0 via reciprocal: floor(x/5) = (x*205) >> 10 for x < 1024
    function automatic logic mod5_is_zero(input logic [7:0] x);
        logic [15:0] prod;
        logic [7:0]  quot;
        logic [7:0]  back;
        prod = x * 16'd205;
        quot = 8'(prod >> 10);
        back = 8'(quot * 8'd5);
        return (back == x);
    endfunction

endpackage
`default_nettype wire

### rtl/lps_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lps_if
// Valid/ready channels for request items and LED results.
// ----------------------------------------------------------------------------
interface lps_item_if;
    logic                           valid;
    logic                           ready;
    logic                           req_type;
    logic [lps_pkg::LEVEL_W-1:0]    level;
    logic [lps_pkg::COLOR_W-1:0]    color;
    logic [lps_pkg::PATTERN_W-1:0]  pattern;

    modport source (output valid, output req_type, output level, output color,
                    output pattern, input ready);
    modport sink   (input valid, input req_type, input level, input color,
                    input pattern, output ready);
endinterface

interface lps_result_if;
    logic                         valid;
    logic                         ready;
    logic [lps_pkg::COLOR_W-1:0]  drive_color;
    logic                         led_on;
    logic [lps_pkg::LEVEL_W-1:0]  active_level;

    modport source (output valid, output drive_color, output led_on,
                    output active_level, input ready);
    modport sink   (input valid, input drive_color, input led_on,
                    input active_level, output ready);
endinterface
`default_nettype wire

### rtl/lps_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lps_cfg_regs
// Timing registers written through the plain configuration port.
// ----------------------------------------------------------------------------
module lps_cfg_regs
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [lps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lps_pkg::CFG_W-1:0]        cfg_data,
    output lps_pkg::cfg_t                         cfg
);

    lps_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_period_ticks <= lps_pkg::PULSE_PERIOD_RST;
            cfg_reg.pulse_width_ticks  <= lps_pkg::PULSE_WIDTH_RST;
            cfg_reg.on_hold_ticks      <= lps_pkg::ON_HOLD_RST;
            cfg_reg.off_hold_ticks     <= lps_pkg::OFF_HOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (lps_pkg::cfg_idx_t'(cfg_index))
                lps_pkg::CFG_PULSE_PERIOD: cfg_reg.pulse_period_ticks <= cfg_data;
                lps_pkg::CFG_PULSE_WIDTH:  cfg_reg.pulse_width_ticks  <= cfg_data;
                lps_pkg::CFG_ON_HOLD:      cfg_reg.on_hold_ticks      <= cfg_data;
                lps_pkg::CFG_OFF_HOLD:     cfg_reg.off_hold_ticks     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

### rtl/lps_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lps_engine
// Level table, pattern state and the combinational per-item step logic.
// ----------------------------------------------------------------------------
module lps_engine
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire lps_pkg::item_t  item,
    input  wire lps_pkg::cfg_t   cfg,
    output lps_pkg::result_t     result
);

    logic [lps_pkg::COLOR_W-1:0]   lvl_color_reg   [lps_pkg::NUM_LEVELS];
    logic [lps_pkg::COLOR_W-1:0]   lvl_color_next  [lps_pkg::NUM_LEVELS];
    logic [lps_pkg::PATTERN_W-1:0] lvl_pat_reg     [lps_pkg::NUM_LEVELS];
    logic [lps_pkg::PATTERN_W-1:0] lvl_pat_next    [lps_pkg::NUM_LEVELS];

    logic [lps_pkg::COLOR_W-1:0] cur_color_reg, cur_color_next;
    logic                        cur_on_reg, cur_on_next;
    logic [2:0]                  slow_div_reg, slow_div_next;
    logic [7:0]                  phase_reg, phase_next;
    logic [7:0]                  poc_reg, poc_next;
    logic [1:0]                  blink_reg, blink_next;
    logic [lps_pkg::COLOR_W-1:0] saved_color_reg, saved_color_next;
    logic                        saved_on_reg, saved_on_next;
    logic [2:0]                  tog_cnt_reg, tog_cnt_next;
    logic [2:0]                  slow_tog_reg, slow_tog_next;
    logic [7:0]                  hold_reg, hold_next;

    logic [lps_pkg::LEVEL_W-1:0]   act;
    logic [lps_pkg::LVL_IDX_W-1:0] sel;
    logic [lps_pkg::COLOR_W-1:0]   c;
    logic [3:0]                    sd_sum;
    logic [8:0]                    ph_sum;
    logic [7:0]                    poc;
    logic [1:0]                    bs;

    always_comb
    begin
        lvl_color_next   = lvl_color_reg;
        lvl_pat_next     = lvl_pat_reg;
        cur_color_next   = cur_color_reg;
        cur_on_next      = cur_on_reg;
        slow_div_next    = slow_div_reg;
        phase_next       = phase_reg;
        poc_next         = poc_reg;
        blink_next       = blink_reg;
        saved_color_next = saved_color_reg;
        saved_on_next    = saved_on_reg;
        tog_cnt_next     = tog_cnt_reg;
        slow_tog_next    = slow_tog_reg;
        hold_next        = hold_reg;
        sd_sum           = {1'b0, slow_div_reg} + 4'd1;
        ph_sum           = {1'b0, phase_reg} + 9'd1;
        poc              = poc_reg;
        bs               = blink_reg;
        act              = lps_pkg::NO_LEVEL;

        if (item.req_type == lps_pkg::REQ_SET)
        begin
            if (int'(item.level) < lps_pkg::NUM_LEVELS)
            begin
                lvl_color_next[lps_pkg::LVL_IDX_W'(item.level)] = item.color;
                lvl_pat_next[lps_pkg::LVL_IDX_W'(item.level)]   = item.pattern;
            end
        end
        else
        begin
            slow_div_next = (sd_sum >= {1'b0, lps_pkg::SLOW_DIV}) ? 3'd0 : sd_sum[2:0];
        end

        for (int i = lps_pkg::NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (lvl_pat_next[i] != lps_pkg::PAT_IDLE)
            begin
                act = lps_pkg::LEVEL_W'(i);
            end
        end

        sel = lps_pkg::LVL_IDX_W'(act);
        c   = lvl_color_reg[sel];

        if (item.req_type == lps_pkg::REQ_TICK && act != lps_pkg::NO_LEVEL)
        begin
            case (lvl_pat_reg[sel])
                lps_pkg::PAT_ON:
                begin
                    cur_color_next = c;
                    cur_on_next    = 1'b1;
                end
                lps_pkg::PAT_OFF:
                begin
                    cur_color_next = c;
                    cur_on_next    = 1'b0;
                end
                lps_pkg::PAT_PULSE:
                begin
                    if (phase_reg == 8'd0)
                    begin
                        cur_color_next = c;
                        cur_on_next    = 1'b1;
                        poc            = 8'd0;
                    end
                    else if (poc_reg == cfg.pulse_width_ticks)
                    begin
                        cur_color_next = c;
                        cur_on_next    = 1'b0;
                    end
                    if (poc != lps_pkg::SAT_MAX)
                    begin
                        poc = poc + 8'd1;
                    end
                    poc_next   = poc;
                    phase_next = (ph_sum >= {1'b0, cfg.pulse_period_ticks}) ?
                                 8'd0 : ph_sum[7:0];
                end
                lps_pkg::PAT_BLINK:
                begin
                    case (blink_reg)
                        2'd0:
                        begin
                            saved_color_next = cur_color_reg;
                            saved_on_next    = cur_on_reg;
                            cur_color_next   = c;
                            cur_on_next      = ~cur_on_reg;
                            if (!cur_on_reg)
                            begin
                                bs = 2'd1;
                            end
                        end
                        2'd1:
                        begin
                            cur_color_next = c;
                            cur_on_next    = 1'b1;
                        end
                        2'd2:
                        begin
                            cur_color_next = c;
                            cur_on_next    = 1'b0;
                        end
                        default:
                        begin
                            cur_color_next     = saved_color_reg;
                            cur_on_next        = saved_on_reg;
                            bs                 = 2'd0;
                            lvl_color_next[sel] = '0;
                            lvl_pat_next[sel]   = lps_pkg::PAT_IDLE;
                        end
                    endcase
                    blink_next = bs + 2'd1;
                end
                lps_pkg::PAT_TOGGLE6:
                begin
                    cur_color_next = c;
                    cur_on_next    = ~cur_on_reg;
                    if (tog_cnt_reg == lps_pkg::SIX_MINUS_ONE)
                    begin
                        tog_cnt_next        = 3'd0;
                        lvl_color_next[sel] = '0;
                        lvl_pat_next[sel]   = lps_pkg::PAT_IDLE;
                    end
                    else
                    begin
                        tog_cnt_next = tog_cnt_reg + 3'd1;
                    end
                end
                lps_pkg::PAT_TOGGLE:
                begin
                    cur_color_next = c;
                    cur_on_next    = ~cur_on_reg;
                end
                lps_pkg::PAT_SLOW:
                begin
                    if (slow_div_next == 3'd0)
                    begin
                        cur_color_next = c;
                        cur_on_next    = ~cur_on_reg;
                    end
                end
                lps_pkg::PAT_ON_TIMED:
                begin
                    if (hold_reg == 8'd0)
                    begin
                        cur_color_next = c;
                        cur_on_next    = 1'b1;
                        hold_next      = hold_reg + 8'd1;
                    end
                    else if (hold_reg == cfg.on_hold_ticks)
                    begin
                        cur_color_next      = c;
                        cur_on_next         = 1'b0;
                        hold_next           = 8'd0;
                        lvl_color_next[sel] = '0;
                        lvl_pat_next[sel]   = lps_pkg::PAT_IDLE;
                    end
                    else
                    begin
                        hold_next = hold_reg + 8'd1;
                    end
                end
                lps_pkg::PAT_SLOW6:
                begin
                    hold_next = hold_reg + 8'd1;
                    if (lps_pkg::mod5_is_zero(hold_reg))
                    begin
                        cur_color_next = c;
                        cur_on_next    = ~cur_on_reg;
                        if (slow_tog_reg == lps_pkg::SIX_MINUS_ONE)
                        begin
                            slow_tog_next       = 3'd0;
                            hold_next           = 8'd0;
                            lvl_color_next[sel] = '0;
                            lvl_pat_next[sel]   = lps_pkg::PAT_IDLE;
                        end
                        else
                        begin
                            slow_tog_next = slow_tog_reg + 3'd1;
                        end
                    end
                end
                lps_pkg::PAT_OFF_TIMED:
                begin
                    if (hold_reg == 8'd0)
                    begin
                        cur_color_next = c;
                        cur_on_next    = 1'b0;
                        hold_next      = hold_reg + 8'd1;
                    end
                    else if (hold_reg == cfg.off_hold_ticks)
                    begin
                        hold_next           = 8'd0;
                        lvl_color_next[sel] = '0;
                        lvl_pat_next[sel]   = lps_pkg::PAT_IDLE;
                    end
                    else
                    begin
                        hold_next = hold_reg + 8'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lps_pkg::NUM_LEVELS; i++)
            begin
                lvl_color_reg[i] <= '0;
                lvl_pat_reg[i]   <= lps_pkg::PAT_IDLE;
            end
            cur_color_reg   <= '0;
            cur_on_reg      <= 1'b0;
            slow_div_reg    <= 3'd0;
            phase_reg       <= 8'd0;
            poc_reg         <= 8'd0;
            blink_reg       <= 2'd0;
            saved_color_reg <= '0;
            saved_on_reg    <= 1'b0;
            tog_cnt_reg     <= 3'd0;
            slow_tog_reg    <= 3'd0;
            hold_reg        <= 8'd0;
        end
        else if (step)
        begin
            lvl_color_reg   <= lvl_color_next;
            lvl_pat_reg     <= lvl_pat_next;
            cur_color_reg   <= cur_color_next;
            cur_on_reg      <= cur_on_next;
            slow_div_reg    <= slow_div_next;
            phase_reg       <= phase_next;
            poc_reg         <= poc_next;
            blink_reg       <= blink_next;
            saved_color_reg <= saved_color_next;
            saved_on_reg    <= saved_on_next;
            tog_cnt_reg     <= tog_cnt_next;
            slow_tog_reg    <= slow_tog_next;
            hold_reg        <= hold_next;
        end
    end

    assign result.drive_color  = cur_color_next;
    assign result.led_on       = cur_on_next;
    assign result.active_level = act;

    // divider and toggle counters stay within their cycle
    a_slow_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        slow_div_reg < lps_pkg::SLOW_DIV)
        else $error("slow divider out of range");

    a_tog_range: assert property (@(posedge clk) disable iff (!rst_n)
        tog_cnt_reg <= lps_pkg::SIX_MINUS_ONE && slow_tog_reg <= lps_pkg::SIX_MINUS_ONE)
        else $error("toggle counter out of range");

    // set requests leave the tick divider and LED alone
    a_set_keeps_div: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.req_type == lps_pkg::REQ_SET
        |=> $stable(slow_div_reg) && $stable(cur_color_reg) && $stable(cur_on_reg))
        else $error("set request changed tick state");

    // no step, no state change
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(hold_reg) && $stable(phase_reg) && $stable(blink_reg))
        else $error("pattern state moved without a step");

endmodule
`default_nettype wire

### rtl/led_pattern_priority_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_pattern_priority_sequencer
// Three-level priority LED pattern sequencer with timed and one-shot patterns.
// ----------------------------------------------------------------------------
// The step logic updates all state; item goes via input reg, then result reg.
// Throughput: one item per cycle unless the result stage stalls on result.ready.
// Reset: rst_n async low; all levels idle, LED dark, timing regs at defaults.
// No clearing pass; items are taken from the first cycle after reset.
module led_pattern_priority_sequencer
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    lps_item_if.sink                            item,
    lps_result_if.source                        result,
    input  wire logic                           cfg_we,
    input  wire logic [lps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lps_pkg::CFG_W-1:0]      cfg_data
);

    logic              in_valid_reg;
    lps_pkg::item_t    in_item_reg;
    logic              out_valid_reg;
    lps_pkg::result_t  out_data_reg;
    logic              advance;
    logic              item_xfer;
    lps_pkg::cfg_t     cfg;
    lps_pkg::result_t  step_result;

    assign advance   = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign item_xfer = item.valid && item.ready;

    lps_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lps_engine u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_xfer)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            in_item_reg.req_type <= item.req_type;
            in_item_reg.level    <= item.level;
            in_item_reg.color    <= item.color;
            in_item_reg.pattern  <= item.pattern;
        end
        if (advance)
        begin
            out_data_reg <= step_result;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.drive_color  = out_data_reg.drive_color;
    assign result.led_on       = out_data_reg.led_on;
    assign result.active_level = out_data_reg.active_level;

endmodule
`default_nettype wire
